[src/spfp_pkg.sv]
// types and constants shared by the sensor packet parser modules
package spfp_pkg;

  localparam int unsigned NUM_FIELDS = 6;
  localparam logic [5:0] PKT_LAST = 6'd40;
  localparam logic [5:0] POS_CR = 6'd39;
  localparam logic [5:0] POS_KIND = 6'd37;
  localparam logic [5:0] POS_START = 6'd0;
  localparam logic [5:0] FIELD_START [NUM_FIELDS] = '{6'd1, 6'd13, 6'd17, 6'd22, 6'd27, 6'd32};

  localparam logic [7:0] CH_SEMI = 8'h3b;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_PLUS = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_M = 8'h4d;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_N = 8'h4e;
  localparam logic [7:0] CH_Z = 8'h5a;

  localparam logic [2:0] KIND_S = 3'd0;
  localparam logic [2:0] KIND_M = 3'd1;
  localparam logic [2:0] KIND_A = 3'd2;
  localparam logic [2:0] KIND_N = 3'd3;
  localparam logic [2:0] KIND_Z = 3'd4;

  localparam logic [15:0] MAG_LIMIT = 16'd32768;
  localparam logic [15:0] POS_MAX = 16'h7fff;
  localparam logic signed [14:0] COMB_SCALE = 15'sd10000;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW = 1;

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_BLANK = 2'd1,
    PH_DIGIT = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef struct packed {
    logic                         ok;
    logic [2:0]                   kind;
    logic [NUM_FIELDS-1:0]        neg;
    logic [NUM_FIELDS-1:0][15:0]  mag;
  } pkt_rec_t;

endpackage

[src/spfp_front.sv]
// byte front end: frame check, kind decode and per-field decimal parsing
module spfp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  input  logic              byte_func,
  input  logic [7:0]        byte_data,
  output logic              byte_ready,
  input  logic              q_full,
  output logic              q_push,
  output spfp_pkg::pkt_rec_t q_rec
);
  import spfp_pkg::*;

  logic [5:0]                  pos_r;
  logic [NUM_FIELDS-1:0][15:0] mag_r, mag_nxt;
  logic [NUM_FIELDS-1:0]       neg_r, neg_nxt;
  phase_t                      ph_r [NUM_FIELDS];
  phase_t                      ph_nxt [NUM_FIELDS];
  logic                        ok_r, ok_nxt;
  logic [2:0]                  kind_r, kind_nxt;
  logic                        accept;
  logic                        is_blank, is_digit;
  logic [3:0]                  digit;
  logic [18:0]                 prod;
  phase_t                      ph_cur;

  assign byte_ready = !q_full;
  assign accept = byte_valid && byte_ready;
  assign is_blank = byte_data inside {8'h20, [8'h09:8'h0d]};
  assign is_digit = byte_data inside {[8'h30:8'h39]};
  assign digit = byte_data[3:0];

  always_comb begin
    prod = '0;
    ph_cur = PH_WAIT;
    for (int f = 0; f < NUM_FIELDS; f++) begin
      mag_nxt[f] = mag_r[f];
      neg_nxt[f] = neg_r[f];
      ph_cur = (pos_r == FIELD_START[f]) ? PH_BLANK : ph_r[f];
      ph_nxt[f] = ph_cur;
      prod = {3'd0, mag_r[f]} * 19'd10 + {15'd0, digit};
      case (ph_cur)
        PH_BLANK: begin
          if (is_blank) begin
            ph_nxt[f] = PH_BLANK;
          end else if (byte_data == CH_PLUS) begin
            ph_nxt[f] = PH_DIGIT;
          end else if (byte_data == CH_MINUS) begin
            neg_nxt[f] = 1'b1;
            ph_nxt[f] = PH_DIGIT;
          end else if (is_digit) begin
            mag_nxt[f] = (prod > {3'd0, MAG_LIMIT}) ? MAG_LIMIT : prod[15:0];
            ph_nxt[f] = PH_DIGIT;
          end else begin
            ph_nxt[f] = PH_DONE;
          end
        end
        PH_DIGIT: begin
          if (is_digit) begin
            mag_nxt[f] = (prod > {3'd0, MAG_LIMIT}) ? MAG_LIMIT : prod[15:0];
          end else begin
            ph_nxt[f] = PH_DONE;
          end
        end
        default: ;
      endcase
    end

    ok_nxt = ok_r;
    kind_nxt = kind_r;
    if (pos_r == POS_START && byte_data != CH_SEMI) ok_nxt = 1'b0;
    if (pos_r == POS_CR && byte_data != CH_CR) ok_nxt = 1'b0;
    if (pos_r == PKT_LAST && byte_data != CH_LF) ok_nxt = 1'b0;
    if (pos_r == POS_KIND) begin
      case (byte_data)
        CH_S: kind_nxt = KIND_S;
        CH_M: kind_nxt = KIND_M;
        CH_A: kind_nxt = KIND_A;
        CH_N: kind_nxt = KIND_N;
        CH_Z: kind_nxt = KIND_Z;
        default: begin
          kind_nxt = KIND_S;
          ok_nxt = 1'b0;
        end
      endcase
    end
  end

  assign q_push = accept && !byte_func && (pos_r == PKT_LAST);
  assign q_rec.ok = ok_nxt;
  assign q_rec.kind = kind_nxt;
  assign q_rec.neg = neg_nxt;
  assign q_rec.mag = mag_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && (byte_func || pos_r == PKT_LAST))) begin
      pos_r <= '0;
      mag_r <= '0;
      neg_r <= '0;
      ok_r <= 1'b1;
      kind_r <= KIND_S;
      for (int f = 0; f < NUM_FIELDS; f++) ph_r[f] <= PH_WAIT;
    end else if (accept) begin
      pos_r <= pos_r + 6'd1;
      mag_r <= mag_nxt;
      neg_r <= neg_nxt;
      ok_r <= ok_nxt;
      kind_r <= kind_nxt;
      for (int f = 0; f < NUM_FIELDS; f++) ph_r[f] <= ph_nxt[f];
    end
  end

endmodule

[src/spfp_queue.sv]
// short queue of parsed packet records between front and back end
module spfp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  spfp_pkg::pkt_rec_t push_rec,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output spfp_pkg::pkt_rec_t pop_rec
);
  import spfp_pkg::*;

  pkt_rec_t       mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   count_r;
  logic            do_push, do_pop;

  assign full = (count_r == Q_AW'(0) + (Q_AW+1)'(Q_DEPTH));
  assign empty = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_rec = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      case ({do_push, do_pop})
        2'b10: count_r <= count_r + (Q_AW+1)'(1);
        2'b01: count_r <= count_r - (Q_AW+1)'(1);
        default: ;
      endcase
    end
  end

endmodule

[src/spfp_back.sv]
// back end: value conversion, combined value multiply-add and result register
module spfp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  spfp_pkg::pkt_rec_t q_rec,
  output logic               q_pop,
  output logic               res_valid,
  input  logic               res_ready,
  output logic               res_status,
  output logic [2:0]         res_kind,
  output logic [spfp_pkg::NUM_FIELDS-1:0][15:0] res_val,
  output logic [29:0]        res_comb
);
  import spfp_pkg::*;

  logic                        en;
  logic                        s1_v_r, s2_v_r, out_v_r;
  logic                        s1_stat_r, s2_stat_r, out_stat_r;
  logic [2:0]                  s1_kind_r, s2_kind_r, out_kind_r;
  logic [NUM_FIELDS-1:0][15:0] s1_val_r, s2_val_r, out_val_r;
  logic [NUM_FIELDS-1:0][15:0] val_c;
  logic                        s1_comb_en_r, s2_comb_en_r;
  logic signed [30:0]          prod_c;
  logic signed [29:0]          s2_prod_r;
  logic [29:0]                 out_comb_r;

  assign en = !out_v_r || res_ready;
  assign q_pop = en && !q_empty;

  always_comb begin
    for (int f = 0; f < NUM_FIELDS; f++) begin
      if (!q_rec.ok) val_c[f] = '0;
      else if (q_rec.neg[f]) val_c[f] = ~q_rec.mag[f] + 16'd1;
      else if (q_rec.mag[f][15]) val_c[f] = POS_MAX;
      else val_c[f] = q_rec.mag[f];
    end
  end

  assign prod_c = s1_comb_en_r ? ($signed(s1_val_r[3]) * COMB_SCALE) : 31'sd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= !q_empty;
      s2_v_r <= s1_v_r;
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_stat_r <= !q_rec.ok;
      s1_kind_r <= q_rec.ok ? q_rec.kind : 3'd0;
      s1_val_r <= val_c;
      s1_comb_en_r <= q_rec.ok && (q_rec.kind == KIND_M || q_rec.kind == KIND_N);
      s2_stat_r <= s1_stat_r;
      s2_kind_r <= s1_kind_r;
      s2_val_r <= s1_val_r;
      s2_comb_en_r <= s1_comb_en_r;
      s2_prod_r <= prod_c[29:0];
      out_stat_r <= s2_stat_r;
      out_kind_r <= s2_kind_r;
      out_val_r <= s2_val_r;
      out_comb_r <= s2_comb_en_r ? (s2_prod_r + {{14{s2_val_r[4][15]}}, s2_val_r[4]}) : '0;
    end
  end

  assign res_valid = out_v_r;
  assign res_status = out_stat_r;
  assign res_kind = out_kind_r;
  assign res_val = out_val_r;
  assign res_comb = out_comb_r;

endmodule

[src/sensor_packet_field_parser.sv]
// top level of the sensor packet field parser
// Takes one byte of a 41-byte ASCII sensor packet per word, one word per cycle while the
// queue is not full; in_tuser high drops the partial packet. Each byte is checked and fed
// to six decimal field parsers as it arrives, and the 41st byte posts a packet record into
// a two-entry queue. A three-stage back end turns the record into saturated 16-bit values
// and, for kinds M and N, value_first*10000+value_second (else zero). Input stalls only
// when the queue is full and the output is held.
module sensor_packet_field_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic [0:0]   in_tuser,   // func
  output logic         out_tvalid,
  input  logic         out_tready,
  // node_id, link_quality, battery_level, value_first, value_second, value_third,
  // combined_value, two zero bits
  output logic [127:0] out_tdata,
  output logic [3:0]   out_tuser   // status, sensor_kind
);
  import spfp_pkg::*;

  logic                        q_full, q_empty, q_push, q_pop;
  pkt_rec_t                    push_rec, pop_rec;
  logic                        res_status;
  logic [2:0]                  res_kind;
  logic [NUM_FIELDS-1:0][15:0] res_val;
  logic [29:0]                 res_comb;

  spfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_tvalid),
    .byte_func  (in_tuser[0]),
    .byte_data  (in_tdata),
    .byte_ready (in_tready),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_rec      (push_rec)
  );

  spfp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_rec  (pop_rec)
  );

  spfp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_rec      (pop_rec),
    .q_pop      (q_pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_status (res_status),
    .res_kind   (res_kind),
    .res_val    (res_val),
    .res_comb   (res_comb)
  );

  assign out_tuser = {res_kind, res_status};
  assign out_tdata = {2'b00, res_comb, res_val};

endmodule
